// ----- rtl/rmrd_pkg.sv -----
// Shared types and constants for the run-length monochrome raster decoder.
// No dependencies; used by every module of the block.
package rmrd_pkg;

    // Character codes
    localparam logic [6:0] C_BEL    = 7'd7;
    localparam logic [6:0] C_ESC    = 7'd27;
    localparam logic [6:0] C_LET_G  = 7'h47;
    localparam logic [6:0] C_LET_Y  = 7'h59;
    localparam logic [6:0] RUN_BIAS = 7'd32;
    localparam logic [7:0] POS_BIAS = 8'd31;

    // Row widths
    localparam logic [8:0] W_MED  = 9'd128;
    localparam logic [8:0] W_HIGH = 9'd256;
    localparam logic [7:0] M_MED  = 8'h7F;
    localparam logic [7:0] M_HIGH = 8'hFF;

    // Escape sequence positions
    localparam logic [1:0] ESC_LETTER = 2'd0;
    localparam logic [1:0] ESC_ARG1   = 2'd1;
    localparam logic [1:0] ESC_ARG2   = 2'd2;

    // Result kinds
    localparam logic [1:0] K_SPAN = 2'd0;
    localparam logic [1:0] K_CR   = 2'd1;
    localparam logic [1:0] K_END  = 2'd2;

    // Job queue address width (four entries)
    localparam int Q_AW = 2;

    // One decoded byte: up to two spans, the second always at column 0
    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] row;
        logic [7:0] col;
        logic [6:0] len;
        logic       two;
        logic [7:0] row2;
        logic [6:0] len2;
    } t_job;

endpackage

// ----- rtl/rmrd_front.sv -----
// Front end: accepts bytes, tracks escape and cursor state, emits one job per
// byte that has results. Depends on rmrd_pkg.
module rmrd_front (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_high_res,
    input  logic             i_cfg_we,
    input  logic             i_cfg_data,
    input  logic             i_accept,
    input  logic [6:0]       i_data_byte,
    output logic             o_push,
    output rmrd_pkg::t_job   o_job
);

    logic       r_in_escape, n_in_escape;
    logic [1:0] r_esc_count, n_esc_count;
    logic [6:0] r_esc_letter, n_esc_letter;
    logic [6:0] r_esc_row, n_esc_row;
    logic       r_skip, n_skip;
    logic [7:0] r_col, n_col;
    logic [7:0] r_row, n_row;

    logic [8:0] w;
    logic [7:0] mask;
    logic [6:0] len;
    logic [7:0] col;
    logic [8:0] room;
    logic [6:0] first;
    logic [8:0] sum;
    logic [8:0] endc;
    logic       has_res;
    rmrd_pkg::t_job job;

    always_comb begin
        w     = i_high_res ? rmrd_pkg::W_HIGH : rmrd_pkg::W_MED;
        mask  = i_high_res ? rmrd_pkg::M_HIGH : rmrd_pkg::M_MED;
        len   = (i_data_byte >= rmrd_pkg::RUN_BIAS) ? i_data_byte - rmrd_pkg::RUN_BIAS : 7'd0;
        col   = r_col & mask;
        room  = w - {1'b0, col};
        first = ({2'b00, len} < room) ? len : room[6:0];
        sum   = {1'b0, col} + {2'b00, len};
        endc  = {1'b0, col} + {2'b00, first};

        n_in_escape  = r_in_escape;
        n_esc_count  = r_esc_count;
        n_esc_letter = r_esc_letter;
        n_esc_row    = r_esc_row;
        n_skip       = r_skip;
        n_col        = r_col;
        n_row        = r_row;
        has_res      = 1'b0;
        job          = '0;

        if (r_in_escape) begin
            if (r_esc_count == rmrd_pkg::ESC_LETTER) begin
                n_esc_letter = i_data_byte;
                n_esc_count  = rmrd_pkg::ESC_ARG1;
                if (i_data_byte != rmrd_pkg::C_LET_G && i_data_byte != rmrd_pkg::C_LET_Y) begin
                    n_in_escape = 1'b0;
                    n_esc_count = rmrd_pkg::ESC_LETTER;
                end
            end else if (r_esc_letter == rmrd_pkg::C_LET_G) begin
                n_in_escape = 1'b0;
                n_esc_count = rmrd_pkg::ESC_LETTER;
                has_res     = 1'b1;
                job.kind    = rmrd_pkg::K_END;
            end else if (r_esc_letter == rmrd_pkg::C_LET_Y
                         && r_esc_count == rmrd_pkg::ESC_ARG1) begin
                n_esc_row   = i_data_byte;
                n_esc_count = rmrd_pkg::ESC_ARG2;
            end else if (r_esc_letter == rmrd_pkg::C_LET_Y) begin
                n_row       = {1'b0, r_esc_row} - rmrd_pkg::POS_BIAS;
                n_col       = ({1'b0, i_data_byte} - rmrd_pkg::POS_BIAS) & mask;
                n_in_escape = 1'b0;
                n_esc_count = rmrd_pkg::ESC_LETTER;
            end else begin
                n_in_escape = 1'b0;
                n_esc_count = rmrd_pkg::ESC_LETTER;
            end
        end else if (i_data_byte == rmrd_pkg::C_BEL) begin
            has_res  = 1'b1;
            job.kind = rmrd_pkg::K_CR;
        end else if (i_data_byte == rmrd_pkg::C_ESC) begin
            n_in_escape = 1'b1;
            n_esc_count = rmrd_pkg::ESC_LETTER;
            n_skip      = 1'b0;
        end else if (r_skip) begin
            // skip run: advance the cursor, wrap into the next row
            if (sum >= w) begin
                n_col = 8'(sum - w);
                n_row = r_row + 8'd1;
            end else begin
                n_col = sum[7:0];
            end
            n_skip = 1'b0;
        end else begin
            n_skip = 1'b1;
            if (len != 7'd0) begin
                has_res  = 1'b1;
                job.kind = rmrd_pkg::K_SPAN;
                job.row  = r_row;
                job.col  = col;
                job.len  = first;
                if (endc >= w) begin
                    n_col = 8'd0;
                    n_row = r_row + 8'd1;
                end else begin
                    n_col = endc[7:0];
                end
                if (len > first) begin
                    job.two  = 1'b1;
                    job.row2 = n_row;
                    job.len2 = len - first;
                    n_col    = {1'b0, len - first};
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_escape  <= 1'b0;
            r_esc_count  <= rmrd_pkg::ESC_LETTER;
            r_esc_letter <= 7'd0;
            r_esc_row    <= 7'd0;
            r_skip       <= 1'b0;
            r_col        <= 8'd0;
            r_row        <= 8'd0;
        end else if (i_accept) begin
            r_in_escape  <= n_in_escape;
            r_esc_count  <= n_esc_count;
            r_esc_letter <= n_esc_letter;
            r_esc_row    <= n_esc_row;
            r_skip       <= n_skip;
            r_col        <= n_col;
            r_row        <= n_row;
        end else if (i_cfg_we && !i_cfg_data) begin
            // narrower rows: fold the cursor into them
            r_col <= r_col & rmrd_pkg::M_MED;
        end
    end

    assign o_push = i_accept && has_res;
    assign o_job  = job;

endmodule

// ----- rtl/rmrd_queue.sv -----
// Four-entry show-ahead job queue between front and back end.
// Depends on rmrd_pkg.
module rmrd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  rmrd_pkg::t_job   i_job,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output rmrd_pkg::t_job   o_job
);

    localparam int DEPTH = 1 << rmrd_pkg::Q_AW;

    rmrd_pkg::t_job r_mem [DEPTH];
    logic [rmrd_pkg::Q_AW:0] r_wr, r_rd;

    assign o_empty = (r_wr == r_rd);
    assign o_full  = (r_wr[rmrd_pkg::Q_AW] != r_rd[rmrd_pkg::Q_AW])
                  && (r_wr[rmrd_pkg::Q_AW-1:0] == r_rd[rmrd_pkg::Q_AW-1:0]);
    assign o_job   = r_mem[r_rd[rmrd_pkg::Q_AW-1:0]];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr[rmrd_pkg::Q_AW-1:0]] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
        end
    end

endmodule

// ----- rtl/rmrd_back.sv -----
// Back end: expands queued jobs into results, one per cycle while not stalled,
// through an output register. Depends on rmrd_pkg.
module rmrd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_empty,
    input  rmrd_pkg::t_job   i_job,
    output logic             o_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [1:0]       o_result_kind,
    output logic [7:0]       o_span_row,
    output logic [7:0]       o_span_col,
    output logic [6:0]       o_span_len,
    output logic             o_last_of_run
);

    logic       r_valid;
    logic       r_pend;
    logic [1:0] r_kind;
    logic [7:0] r_row, r_col, r_row2;
    logic [6:0] r_len, r_len2;
    logic       r_last;
    logic       load;

    assign load  = !r_valid || !i_out_stall;
    assign o_pop = load && !r_pend && !i_q_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_pend  <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_valid <= 1'b1;
                r_pend  <= 1'b0;
            end else begin
                r_valid <= !i_q_empty;
                r_pend  <= !i_q_empty && i_job.two;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_kind <= rmrd_pkg::K_SPAN;
                r_row  <= r_row2;
                r_col  <= 8'd0;
                r_len  <= r_len2;
                r_last <= 1'b1;
            end else begin
                r_kind <= i_job.kind;
                r_row  <= i_job.row;
                r_col  <= i_job.col;
                r_len  <= i_job.len;
                r_last <= !i_job.two;
                r_row2 <= i_job.row2;
                r_len2 <= i_job.len2;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_result_kind = r_kind;
    assign o_span_row    = r_row;
    assign o_span_col    = r_col;
    assign o_span_len    = r_len;
    assign o_last_of_run = r_last;

endmodule

// ----- rtl/rle_mono_raster_decoder.sv -----
// Top level of the run-length monochrome raster decoder.
// Depends on rmrd_pkg, rmrd_front, rmrd_queue and rmrd_back.
//
// Input: i_in_valid / o_in_stall carry one 7-bit character (i_data_byte); an
//   item is taken at a clock edge with valid high and stall low. o_in_stall
//   rises only while the four-entry job queue is full.
// Output: o_out_valid / i_out_stall carry one result item per edge: a black
//   span (row, first column, length), a CR reply request or graphics end.
//   o_last_of_run marks the final item caused by a character.
// Configuration: i_cfg_valid / o_cfg_ready write high_res (i_cfg_data);
//   ready is always high. Write only while the block is idle.
// Timing: a character is decoded and its job queued at the edge that takes
//   it; the back end loads the output register from the head job, or from
//   a pending second span, whenever it is empty or not stalled. Characters
//   enter at one a cycle while the queue is not full; one result leaves a
//   cycle while i_out_stall is low, so a character that splits into two
//   spans gives two results through the single output register.
// Reset: synchronous, active low: cursor at row 0 column 0, draw phase, no
//   escape, 128-pixel rows, queue and output empty.
// Stalls: while i_out_stall is high the result holds; decoding carries on
//   until the queue fills, then o_in_stall holds off the sender.
module rle_mono_raster_decoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_cfg_data,
    // character input
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [6:0] i_data_byte,
    // result output
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_result_kind,
    output logic [7:0] o_span_row,
    output logic [7:0] o_span_col,
    output logic [6:0] o_span_len,
    output logic       o_last_of_run
);

    logic           r_high_res;
    logic           cfg_we;
    logic           accept;
    logic           push, pop, q_full, q_empty;
    rmrd_pkg::t_job front_job, head_job;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign o_in_stall  = q_full;
    assign accept      = i_in_valid && !o_in_stall;

    // hold the resolution setting
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high_res <= 1'b0;
        end else if (cfg_we) begin
            r_high_res <= i_cfg_data;
        end
    end

    rmrd_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_high_res  (r_high_res),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .o_push      (push),
        .o_job       (front_job)
    );

    rmrd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    rmrd_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_job         (head_job),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_result_kind (o_result_kind),
        .o_span_row    (o_span_row),
        .o_span_col    (o_span_col),
        .o_span_len    (o_span_len),
        .o_last_of_run (o_last_of_run)
    );

    // a span is never empty and stays within its row
    a_span_in_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind == rmrd_pkg::K_SPAN) |->
            (o_span_len != 7'd0
             && ({1'b0, o_span_col} + {2'b00, o_span_len})
                <= (r_high_res ? rmrd_pkg::W_HIGH : rmrd_pkg::W_MED)))
        else $error("span empty or past end of row");

    // the first span of a split run, once taken, is followed at once by its second
    a_split_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last_of_run && !i_out_stall) |=>
            (o_out_valid && o_result_kind == rmrd_pkg::K_SPAN
             && o_span_col == 8'd0 && o_last_of_run))
        else $error("second span of a split run missing");

    // replies and graphics end are single, last items
    a_single_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_result_kind != rmrd_pkg::K_SPAN) |-> o_last_of_run)
        else $error("non-span result not marked last");

endmodule
